>>> sv/rswmf_pkg.sv
`timescale 1ns / 1ps

package rswmf_pkg;

  localparam int MAX_RADIUS = 3;
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int RING_LINES = 2 * MAX_RADIUS + 1;
  localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
  localparam int WIN_N      = WIN_SIDE * WIN_SIDE;

  localparam int CH_W      = 8;
  localparam int NCH       = 3;
  localparam int PIX_W     = NCH * CH_W;
  localparam int R_W       = 2;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int W_W       = $clog2(MAX_WIDTH + 1);
  localparam int H_W       = $clog2(MAX_HEIGHT + 1);
  localparam int OLINE_W   = $clog2(MAX_HEIGHT);
  localparam int ILINE_W   = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
  localparam int SLOT_W    = $clog2(RING_LINES);
  localparam int WIDX_W    = $clog2(WIN_SIDE);
  localparam int K_W       = $clog2(WIN_N + 1);
  localparam int DLY_W     = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = H_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_SIDE-1:0] col_t;

  typedef struct packed {
    logic                                 pass;
    logic                                 last;
    pix_t                                 pix;
    logic [NCH-1:0][K_W-1:0]              k;
    logic [NCH-1:0][WIN_N-1:0]            alive;
    logic [NCH-1:0][WIN_N-1:0][CH_W-1:0]  vals;
    logic [NCH-1:0][CH_W-1:0]             res;
  } sel_t;

  // Window positions in use for radius r: column and row both within 2r.
  function automatic logic [WIN_N-1:0] win_mask(logic [R_W-1:0] r);
    logic [WIN_N-1:0] m;
    int               lim;
    lim = 2 * int'(r);
    m   = '0;
    for (int c = 0; c < WIN_SIDE; c++) begin
      for (int w = 0; w < WIN_SIDE; w++) begin
        m[c*WIN_SIDE+w] = (c <= lim) && (w <= lim);
      end
    end
    return m;
  endfunction

  // Zero-based rank of the median in a (2r+1)^2 window.
  function automatic logic [K_W-1:0] med_rank(logic [R_W-1:0] r);
    int side;
    side = 2 * int'(r) + 1;
    return K_W'((side * side) >> 1);
  endfunction

endpackage

>>> sv/rswmf_in_if.sv
`timescale 1ns / 1ps

interface rswmf_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, kind, red, green, blue, input ready);
  modport sink (input valid, kind, red, green, blue, output ready);
endinterface

>>> sv/rswmf_out_if.sv
`timescale 1ns / 1ps

interface rswmf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

>>> sv/rgb_square_window_median_filter_unit.sv
// RGB median filter over a (2r+1) x (2r+1) window, r = 1..3, pixels in raster
// order. Takes one pixel per clock; the result of a transfer passes through the line
// store read, window shift, eight radix-select cells and the output register. While
// a result waits on pix_o.ready the whole pipe holds and pix_i.ready is low. Output
// pixel k comes out for input item k + r*W + r, so each frame must be followed by
// r*W + r flush items (kind = 1). Pixels within r of a frame edge pass through. A
// write to radius, frame_width or frame_height restarts the frame; write only while
// the block is idle. Seven line RAMs of 2048 pixels each hold the last lines; there
// is no clearing pass after reset.
`timescale 1ns / 1ps

module rgb_square_window_median_filter_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  rswmf_in_if.sink                             pix_i,
  rswmf_out_if.source                          pix_o,
  input  logic                                 cfg_we_i,
  input  logic [rswmf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rswmf_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int RL = rswmf_pkg::RING_LINES;
  localparam int WS = rswmf_pkg::WIN_SIDE;

  // ---------------- configuration ----------------
  logic [rswmf_pkg::R_W-1:0]  radius_q;
  logic [rswmf_pkg::W_W-1:0]  width_q;
  logic [rswmf_pkg::H_W-1:0]  height_q;
  logic [rswmf_pkg::R_W-1:0]  r_eff;
  logic [rswmf_pkg::W_W-1:0]  w_eff;
  logic [rswmf_pkg::H_W-1:0]  h_eff;
  logic [rswmf_pkg::DLY_W-1:0] dly;
  logic                        cfg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= rswmf_pkg::R_W'(1);
      width_q  <= rswmf_pkg::W_W'(640);
      height_q <= rswmf_pkg::H_W'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rswmf_pkg::CFG_RADIUS: radius_q <= cfg_data_i[rswmf_pkg::R_W-1:0];
        rswmf_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[rswmf_pkg::W_W-1:0];
        rswmf_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_hit = cfg_we_i && ((cfg_idx_i == rswmf_pkg::CFG_RADIUS) ||
                                (cfg_idx_i == rswmf_pkg::CFG_WIDTH) ||
                                (cfg_idx_i == rswmf_pkg::CFG_HEIGHT));

  // Out-of-range settings clamp to the supported range.
  always_comb begin
    if (radius_q == '0) begin
      r_eff = rswmf_pkg::R_W'(1);
    end else if (radius_q > rswmf_pkg::R_W'(rswmf_pkg::MAX_RADIUS)) begin
      r_eff = rswmf_pkg::R_W'(rswmf_pkg::MAX_RADIUS);
    end else begin
      r_eff = radius_q;
    end
    if (width_q == '0) begin
      w_eff = rswmf_pkg::W_W'(1);
    end else if (width_q > rswmf_pkg::W_W'(rswmf_pkg::MAX_WIDTH)) begin
      w_eff = rswmf_pkg::W_W'(rswmf_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = rswmf_pkg::H_W'(1);
    end else if (height_q > rswmf_pkg::H_W'(rswmf_pkg::MAX_HEIGHT)) begin
      h_eff = rswmf_pkg::H_W'(rswmf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  // Items before the first output: r lines plus r pixels.
  assign dly = rswmf_pkg::DLY_W'(r_eff) * rswmf_pkg::DLY_W'(w_eff) +
               rswmf_pkg::DLY_W'(r_eff);

  // ---------------- flow control ----------------
  logic en;        // whole pipe advances together
  logic accept;
  logic out_valid_q;

  assign en          = !out_valid_q || pix_o.ready;
  assign pix_i.ready = en;
  assign accept      = pix_i.valid && en;

  // ---------------- position counters ----------------
  logic [rswmf_pkg::COL_W-1:0]   in_col_q;
  logic [rswmf_pkg::ILINE_W-1:0] in_line_q;
  logic [rswmf_pkg::SLOT_W-1:0]  slot_q;
  logic [rswmf_pkg::COL_W-1:0]   out_col_q;
  logic [rswmf_pkg::OLINE_W-1:0] out_line_q;
  logic [rswmf_pkg::DLY_W-1:0]   fill_q;
  logic [rswmf_pkg::W_W-1:0]     col_inc;
  logic [rswmf_pkg::W_W-1:0]     ocol_inc;
  logic                          in_wrap;
  logic                          emit;
  logic                          in_frame;
  logic                          edge_pix;
  logic                          last_pix;
  rswmf_pkg::pix_t               in_pix;

  assign col_inc  = rswmf_pkg::W_W'(in_col_q) + rswmf_pkg::W_W'(1);
  assign ocol_inc = rswmf_pkg::W_W'(out_col_q) + rswmf_pkg::W_W'(1);
  assign in_wrap  = col_inc >= w_eff;
  assign emit     = fill_q == dly;
  assign in_frame = in_line_q < rswmf_pkg::ILINE_W'(h_eff);
  assign in_pix   = pix_i.kind ? '0 : {pix_i.red, pix_i.green, pix_i.blue};

  assign edge_pix =
      (out_line_q < rswmf_pkg::OLINE_W'(r_eff)) ||
      (out_col_q < rswmf_pkg::COL_W'(r_eff)) ||
      ((rswmf_pkg::H_W'(out_line_q) + rswmf_pkg::H_W'(r_eff)) >= h_eff) ||
      ((rswmf_pkg::W_W'(out_col_q) + rswmf_pkg::W_W'(r_eff)) >= w_eff);
  assign last_pix = ((rswmf_pkg::H_W'(out_line_q) + rswmf_pkg::H_W'(1)) >= h_eff) &&
                    (ocol_inc >= w_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_line_q  <= '0;
      slot_q     <= '0;
      out_col_q  <= '0;
      out_line_q <= '0;
      fill_q     <= '0;
    end else if (cfg_hit || (accept && emit && last_pix)) begin
      in_col_q   <= '0;
      in_line_q  <= '0;
      slot_q     <= '0;
      out_col_q  <= '0;
      out_line_q <= '0;
      fill_q     <= '0;
    end else if (accept) begin
      if (in_wrap) begin
        in_col_q  <= '0;
        in_line_q <= in_line_q + rswmf_pkg::ILINE_W'(1);
        slot_q    <= (slot_q == rswmf_pkg::SLOT_W'(RL - 1)) ? '0
                                                            : slot_q + rswmf_pkg::SLOT_W'(1);
      end else begin
        in_col_q <= col_inc[rswmf_pkg::COL_W-1:0];
      end
      if (emit) begin
        if (ocol_inc >= w_eff) begin
          out_col_q  <= '0;
          out_line_q <= out_line_q + rswmf_pkg::OLINE_W'(1);
        end else begin
          out_col_q <= ocol_inc[rswmf_pkg::COL_W-1:0];
        end
      end else begin
        fill_q <= fill_q + rswmf_pkg::DLY_W'(1);
      end
    end
  end

  // ---------------- line store: one RAM per ring line ----------------
  rswmf_pkg::pix_t ram_rd [RL];

  for (genvar s = 0; s < RL; s++) begin : g_line
    rswmf_ram #(
      .WIDTH(rswmf_pkg::PIX_W),
      .DEPTH(rswmf_pkg::MAX_WIDTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (accept && in_frame && (slot_q == rswmf_pkg::SLOT_W'(s))),
      .waddr_i(in_col_q),
      .wdata_i(in_pix),
      .re_i   (accept),
      .raddr_i(in_col_q),
      .rdata_o(ram_rd[s])
    );
  end

  // ---------------- stage 1: RAM data back, new column ----------------
  logic                         v1_q;
  rswmf_pkg::pix_t              pix1_q;
  logic [rswmf_pkg::SLOT_W-1:0] slot1_q;
  logic                         emit1_q;
  logic                         pass1_q;
  logic                         last1_q;
  rswmf_pkg::col_t              col_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix1_q  <= in_pix;
      slot1_q <= slot_q;
      emit1_q <= emit;
      pass1_q <= edge_pix;
      last1_q <= last_pix;
    end
  end

  // Row t holds line (current - t); the current line comes straight from the input.
  always_comb begin
    logic [rswmf_pkg::SLOT_W:0] idx;
    for (int t = 0; t < WS; t++) begin
      idx = (rswmf_pkg::SLOT_W+1)'(slot1_q) + (rswmf_pkg::SLOT_W+1)'(RL) -
            (rswmf_pkg::SLOT_W+1)'(t);
      if (idx >= (rswmf_pkg::SLOT_W+1)'(RL)) begin
        idx = idx - (rswmf_pkg::SLOT_W+1)'(RL);
      end
      col_new[t] = (t == 0) ? pix1_q : ram_rd[idx[rswmf_pkg::SLOT_W-1:0]];
    end
  end

  // ---------------- window: chain of column cells, newest at 0 ----------------
  rswmf_pkg::col_t cols [WS];

  for (genvar j = 0; j < WS; j++) begin : g_col
    rswmf_col_cell u_col (
      .clk_i  (clk_i),
      .shift_i(en && v1_q),
      .col_i  ((j == 0) ? col_new : cols[(j == 0) ? 0 : j - 1]),
      .col_o  (cols[j])
    );
  end

  // ---------------- stage 2: window complete for an output pixel ----------------
  logic v2_q;
  logic pass2_q;
  logic last2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q && emit1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pass2_q <= pass1_q;
      last2_q <= last1_q;
    end
  end

  rswmf_pkg::sel_t sel_in;

  always_comb begin
    sel_in      = '0;
    sel_in.pass = pass2_q;
    sel_in.last = last2_q;
    sel_in.pix  = cols[rswmf_pkg::WIDX_W'(r_eff)][rswmf_pkg::WIDX_W'(r_eff)];
    for (int c = 0; c < rswmf_pkg::NCH; c++) begin
      sel_in.k[c]     = rswmf_pkg::med_rank(r_eff);
      sel_in.alive[c] = rswmf_pkg::win_mask(r_eff);
      for (int x = 0; x < WS; x++) begin
        for (int y = 0; y < WS; y++) begin
          sel_in.vals[c][x*WS+y] = cols[x][y][c*rswmf_pkg::CH_W +: rswmf_pkg::CH_W];
        end
      end
    end
  end

  // ---------------- radix select: one cell per result bit, msb first ----------------
  logic            sel_v [rswmf_pkg::CH_W+1];
  rswmf_pkg::sel_t sel_d [rswmf_pkg::CH_W+1];

  assign sel_v[0] = v2_q;
  assign sel_d[0] = sel_in;

  for (genvar b = 0; b < rswmf_pkg::CH_W; b++) begin : g_sel
    rswmf_sel_cell u_sel (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(sel_v[b]),
      .data_i (sel_d[b]),
      .valid_o(sel_v[b+1]),
      .data_o (sel_d[b+1])
    );
  end

  // ---------------- output register ----------------
  rswmf_pkg::pix_t out_pix_q;
  logic            out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sel_v[rswmf_pkg::CH_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pix_q  <= sel_d[rswmf_pkg::CH_W].pass ? sel_d[rswmf_pkg::CH_W].pix
                                                : sel_d[rswmf_pkg::CH_W].res;
      out_last_q <= sel_d[rswmf_pkg::CH_W].last;
    end
  end

  assign pix_o.valid     = out_valid_q;
  assign pix_o.out_red   = out_pix_q[2*rswmf_pkg::CH_W +: rswmf_pkg::CH_W];
  assign pix_o.out_green = out_pix_q[rswmf_pkg::CH_W +: rswmf_pkg::CH_W];
  assign pix_o.out_blue  = out_pix_q[0 +: rswmf_pkg::CH_W];
  assign pix_o.frame_end = out_last_q;

endmodule

>>> sv/rswmf_ram.sv
`timescale 1ns / 1ps

module rswmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> sv/rswmf_col_cell.sv
`timescale 1ns / 1ps

// One window column; takes its neighbor's column on every shift.
module rswmf_col_cell (
  input  logic                clk_i,
  input  logic                shift_i,
  input  rswmf_pkg::col_t     col_i,
  output rswmf_pkg::col_t     col_o
);

  rswmf_pkg::col_t col_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

>>> sv/rswmf_sel_cell.sv
`timescale 1ns / 1ps

// Radix-select step: settles one median bit (msb of the shifted values) per channel.
module rswmf_sel_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  rswmf_pkg::sel_t data_i,
  output logic            valid_o,
  output rswmf_pkg::sel_t data_o
);

  rswmf_pkg::sel_t data_d, data_q;
  logic            valid_q;

  always_comb begin
    logic [rswmf_pkg::WIN_N-1:0] zeros;
    logic [rswmf_pkg::WIN_N-1:0] ones;
    logic [rswmf_pkg::K_W-1:0]   cnt;
    data_d = data_i;
    for (int c = 0; c < rswmf_pkg::NCH; c++) begin
      for (int i = 0; i < rswmf_pkg::WIN_N; i++) begin
        ones[i]  = data_i.alive[c][i] & data_i.vals[c][i][rswmf_pkg::CH_W-1];
        zeros[i] = data_i.alive[c][i] & ~data_i.vals[c][i][rswmf_pkg::CH_W-1];
        data_d.vals[c][i] = {data_i.vals[c][i][rswmf_pkg::CH_W-2:0], 1'b0};
      end
      cnt = '0;
      for (int i = 0; i < rswmf_pkg::WIN_N; i++) begin
        cnt = cnt + rswmf_pkg::K_W'(zeros[i]);
      end
      if (data_i.k[c] < cnt) begin
        data_d.alive[c] = zeros;
        data_d.res[c]   = {data_i.res[c][rswmf_pkg::CH_W-2:0], 1'b0};
      end else begin
        data_d.alive[c] = ones;
        data_d.k[c]     = data_i.k[c] - cnt;
        data_d.res[c]   = {data_i.res[c][rswmf_pkg::CH_W-2:0], 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
